// ===== rtl/qn_pkg.sv =====
// Shared types and constants for the quaternion normalizer.
package qn_pkg;

    localparam int LANES    = 4;
    localparam int COMP_W   = 32;
    localparam int SQ_W     = 2 * COMP_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int ROOT_W   = 33;
    localparam int FRAC_SH  = 30;
    localparam int QUO_W    = FRAC_SH + 1;
    localparam int DIVD_W   = 64;
    localparam int NORM_W   = 34;
    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_LAT  = QUO_W;

    localparam logic [1:0] ORDER_L1 = 2'd1;
    localparam logic [1:0] ORDER_L2 = 2'd2;

    // Side data that travels beside the square root pipeline.
    typedef struct packed {
        logic [LANES-1:0][COMP_W-1:0] mag;
        logic [LANES-1:0]             neg;
        logic [1:0]                   order;
        logic [NORM_W-1:0]            l1;
    } t_sqrt_side;

    // Side data that travels beside the divider lanes.
    typedef struct packed {
        logic [LANES-1:0]  neg;
        logic [1:0]        order;
        logic [NORM_W-1:0] l1;
        logic [ROOT_W-1:0] root;
    } t_div_side;

endpackage

// ===== rtl/qn_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module qn_sqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [qn_pkg::SUM_W-1:0]        i_sum,
    output logic [qn_pkg::ROOT_W-1:0]       o_root
);

    localparam int RW = qn_pkg::SUM_W + 1;

    logic [qn_pkg::SUM_W-1:0] r_rem [qn_pkg::ROOT_W];
    logic [RW-1:0]            r_res [qn_pkg::ROOT_W];

    genvar k;
    generate
        for (k = 0; k < qn_pkg::ROOT_W; k++) begin : g_stage
            localparam logic [RW-1:0] BIT = RW'(1) << (2 * (qn_pkg::ROOT_W - 1 - k));
            logic [qn_pkg::SUM_W-1:0] rem_in;
            logic [RW-1:0]            res_in;
            logic [RW-1:0]            trial;
            logic [qn_pkg::SUM_W-1:0] n_rem;
            logic [RW-1:0]            n_res;

            // The first stage starts from the sum, later stages from the previous one.
            if (k == 0) begin : g_head
                assign rem_in = i_sum;
                assign res_in = '0;
            end else begin : g_tail
                assign rem_in = r_rem[k-1];
                assign res_in = r_res[k-1];
            end

            // One restoring step: subtract the trial value when it fits.
            always_comb begin
                trial = res_in + BIT;
                if ({1'b0, rem_in} >= trial) begin
                    n_rem = rem_in - trial[qn_pkg::SUM_W-1:0];
                    n_res = (res_in >> 1) + BIT;
                end else begin
                    n_rem = rem_in;
                    n_res = res_in >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_res[k] <= n_res;
                end
            end
        end
    endgenerate

    assign o_root = r_res[qn_pkg::ROOT_W-1][qn_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/qn_div_lane.sv =====
// One divider lane: pipelined restoring division of a magnitude by the norm.
module qn_div_lane (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [qn_pkg::COMP_W-1:0]       i_mag,
    input  logic [qn_pkg::ROOT_W-1:0]       i_root,
    output logic [qn_pkg::QUO_W-1:0]        o_quo
);

    logic [qn_pkg::DIVD_W-1:0] r_rem  [qn_pkg::QUO_W];
    logic [qn_pkg::ROOT_W-1:0] r_root [qn_pkg::QUO_W];
    logic [qn_pkg::QUO_W-1:0]  r_quo  [qn_pkg::QUO_W];

    genvar k;
    generate
        for (k = 0; k < qn_pkg::QUO_W; k++) begin : g_stage
            logic [qn_pkg::DIVD_W-1:0] rem_in;
            logic [qn_pkg::ROOT_W-1:0] root_in;
            logic [qn_pkg::QUO_W-1:0]  quo_in;
            logic [qn_pkg::DIVD_W-1:0] dsr;
            logic [qn_pkg::DIVD_W-1:0] n_rem;
            logic [qn_pkg::QUO_W-1:0]  n_quo;

            // The first stage loads the scaled magnitude, later stages the previous one.
            if (k == 0) begin : g_head
                assign rem_in  = qn_pkg::DIVD_W'(i_mag) << qn_pkg::FRAC_SH;
                assign root_in = i_root;
                assign quo_in  = '0;
            end else begin : g_tail
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
                assign quo_in  = r_quo[k-1];
            end

            // Compare against the divisor shifted to this quotient bit.
            always_comb begin
                dsr = qn_pkg::DIVD_W'(root_in) << (qn_pkg::QUO_W - 1 - k);
                if (rem_in >= dsr) begin
                    n_rem = rem_in - dsr;
                    n_quo = {quo_in[qn_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_in;
                    n_quo = {quo_in[qn_pkg::QUO_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= root_in;
                    r_quo[k]  <= n_quo;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[qn_pkg::QUO_W-1];

endmodule

// ===== rtl/quaternion_normalize.sv =====
// Quaternion normalizer: each word is a Q4.28 quaternion; the block returns the unit
// quaternion in Q2.30, the requested L1 or L2 norm in Q6.28, and a zero-norm flag.
// It accepts one word every cycle while the output is not stalled and returns results
// in order through stages A to C for magnitudes, squares and their sum, 33 stages of
// the bit-per-stage square root, 31 stages of the four parallel divider lanes, and the
// output register. A stall on the output freezes the whole pipeline; a one-word skid
// buffer keeps s_axis_tready registered.
module quaternion_normalize (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // comp_w, comp_x, comp_y, comp_z
    input  logic [1:0]    s_axis_tuser,   // norm_order
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [167:0]  m_axis_tdata,   // unit_w, unit_x, unit_y, unit_z, norm_value, pad
    output logic          m_axis_tuser    // zero_norm
);

    localparam int L  = qn_pkg::LANES;
    localparam int CW = qn_pkg::COMP_W;

    logic en;
    logic in_fire;

    // Skid buffer on the input side.
    logic         r_skid_valid;
    logic [127:0] r_skid_data;
    logic [1:0]   r_skid_user;
    logic         src_valid;
    logic [127:0] src_data;
    logic [1:0]   src_user;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign src_valid     = r_skid_valid || in_fire;
    assign src_data      = r_skid_valid ? r_skid_data : s_axis_tdata;
    assign src_user      = r_skid_valid ? r_skid_user : s_axis_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && !en) begin
            r_skid_data <= s_axis_tdata;
            r_skid_user <= s_axis_tuser;
        end
    end

    // Stage A: magnitudes and signs.
    logic                 r_a_valid;
    logic [L-1:0][CW-1:0] r_a_mag;
    logic [L-1:0]         r_a_neg;
    logic [1:0]           r_a_order;
    logic [L-1:0][CW-1:0] n_a_mag;
    logic [L-1:0]         n_a_neg;

    always_comb begin
        for (int i = 0; i < L; i++) begin
            n_a_neg[i] = src_data[i*CW + CW - 1];
            n_a_mag[i] = n_a_neg[i] ? (~src_data[i*CW +: CW] + CW'(1)) : src_data[i*CW +: CW];
        end
    end

    // Stage B: squares.
    logic                             r_b_valid;
    logic [L-1:0][qn_pkg::SQ_W-1:0]   r_b_sq;
    logic [L-1:0][CW-1:0]             r_b_mag;
    logic [L-1:0]                     r_b_neg;
    logic [1:0]                       r_b_order;

    // Stage C: sum of squares and sum of magnitudes.
    logic                       r_c_valid;
    logic [qn_pkg::SUM_W-1:0]   r_c_sum;
    qn_pkg::t_sqrt_side         r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= src_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mag   <= n_a_mag;
            r_a_neg   <= n_a_neg;
            r_a_order <= src_user;
            for (int i = 0; i < L; i++) begin
                r_b_sq[i] <= r_a_mag[i] * r_a_mag[i];
            end
            r_b_mag   <= r_a_mag;
            r_b_neg   <= r_a_neg;
            r_b_order <= r_a_order;
            r_c_sum   <= (qn_pkg::SUM_W'(r_b_sq[0]) + qn_pkg::SUM_W'(r_b_sq[1]))
                       + (qn_pkg::SUM_W'(r_b_sq[2]) + qn_pkg::SUM_W'(r_b_sq[3]));
            r_c_side.mag   <= r_b_mag;
            r_c_side.neg   <= r_b_neg;
            r_c_side.order <= r_b_order;
            r_c_side.l1    <= (qn_pkg::NORM_W'(r_b_mag[0]) + qn_pkg::NORM_W'(r_b_mag[1]))
                            + (qn_pkg::NORM_W'(r_b_mag[2]) + qn_pkg::NORM_W'(r_b_mag[3]));
        end
    end

    // Square root with its side data delayed alongside.
    logic [qn_pkg::ROOT_W-1:0] root;
    logic                      r_s_valid [qn_pkg::SQRT_LAT];
    qn_pkg::t_sqrt_side        r_s_side  [qn_pkg::SQRT_LAT];

    qn_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r_c_sum),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < qn_pkg::SQRT_LAT; i++) begin
                r_s_valid[i] <= 1'b0;
            end
        end else if (en) begin
            r_s_valid[0] <= r_c_valid;
            for (int i = 1; i < qn_pkg::SQRT_LAT; i++) begin
                r_s_valid[i] <= r_s_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_side[0] <= r_c_side;
            for (int i = 1; i < qn_pkg::SQRT_LAT; i++) begin
                r_s_side[i] <= r_s_side[i-1];
            end
        end
    end

    // Divider lanes, one per component.
    qn_pkg::t_sqrt_side            s_side;
    qn_pkg::t_div_side             d_in;
    logic [L-1:0][qn_pkg::QUO_W-1:0] quo;

    assign s_side     = r_s_side[qn_pkg::SQRT_LAT-1];
    assign d_in.neg   = s_side.neg;
    assign d_in.order = s_side.order;
    assign d_in.l1    = s_side.l1;
    assign d_in.root  = root;

    genvar g;
    generate
        for (g = 0; g < L; g++) begin : g_lane
            qn_div_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_mag  (s_side.mag[g]),
                .i_root (root),
                .o_quo  (quo[g])
            );
        end
    endgenerate

    logic              r_d_valid [qn_pkg::DIV_LAT];
    qn_pkg::t_div_side r_d_side  [qn_pkg::DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < qn_pkg::DIV_LAT; i++) begin
                r_d_valid[i] <= 1'b0;
            end
        end else if (en) begin
            r_d_valid[0] <= r_s_valid[qn_pkg::SQRT_LAT-1];
            for (int i = 1; i < qn_pkg::DIV_LAT; i++) begin
                r_d_valid[i] <= r_d_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side[0] <= d_in;
            for (int i = 1; i < qn_pkg::DIV_LAT; i++) begin
                r_d_side[i] <= r_d_side[i-1];
            end
        end
    end

    // Merge: signs, zero-norm override and norm selection.
    qn_pkg::t_div_side     m_side;
    logic                  n_zero;
    logic [L-1:0][CW-1:0]  n_unit;
    logic [qn_pkg::NORM_W-1:0] n_norm;

    assign m_side = r_d_side[qn_pkg::DIV_LAT-1];
    assign n_zero = (m_side.root == '0);

    always_comb begin
        for (int i = 0; i < L; i++) begin
            if (n_zero) begin
                n_unit[i] = '0;
            end else if (m_side.neg[i]) begin
                n_unit[i] = CW'(0) - CW'(quo[i]);
            end else begin
                n_unit[i] = CW'(quo[i]);
            end
        end
        case (m_side.order)
            qn_pkg::ORDER_L1: begin
                n_norm = m_side.l1;
            end
            qn_pkg::ORDER_L2: begin
                n_norm = qn_pkg::NORM_W'(m_side.root);
            end
            default: begin
                n_norm = '0;
            end
        endcase
    end

    // Output register.
    logic                      r_out_valid;
    logic [L-1:0][CW-1:0]      r_out_unit;
    logic [qn_pkg::NORM_W-1:0] r_out_norm;
    logic                      r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_d_valid[qn_pkg::DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_unit <= n_unit;
            r_out_norm <= n_norm;
            r_out_zero <= n_zero;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_norm, r_out_unit};
    assign m_axis_tuser  = r_out_zero;

    // A zero norm forces all unit components to zero.
    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[127:0] == '0)
        else $error("zero norm with nonzero unit output");

    // A zero norm only comes from an all-zero input, so either norm is zero.
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[161:128] == '0)
        else $error("zero norm with nonzero norm value");

    // A word taken during a stall must land in the skid buffer.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !en |=> r_skid_valid)
        else $error("stalled input word not captured");

    // While stalled, the pipeline valid at the divider output must not change.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_d_valid[qn_pkg::DIV_LAT-1]))
        else $error("pipeline moved during a stall");

endmodule

// ===== tb/quaternion_normalize_checker.sv =====
// Checker for the quaternion normalizer: predicts each result word and compares it.
module quaternion_normalize_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [127:0] i_in_data,
    input  logic [1:0]   i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [167:0] i_out_data,
    input  logic         i_out_user,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] unit_w;
        logic [31:0] unit_x;
        logic [31:0] unit_y;
        logic [31:0] unit_z;
        logic [33:0] norm_value;
        logic        zero_norm;
    } t_unit_quat;

    t_unit_quat unit_queue[$];

    // Integer square root, floor, of a 64-bit sum.
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] one_bit;
        rem = v;
        res = 0;
        one_bit = 64'h1 << 62;
        while (one_bit > v) one_bit = one_bit >> 2;
        while (one_bit != 0) begin
            if (rem >= res + one_bit) begin
                rem = rem - (res + one_bit);
                res = (res >> 1) + one_bit;
            end else begin
                res = res >> 1;
            end
            one_bit = one_bit >> 2;
        end
        return res;
    endfunction

    // Normalize one quaternion and report the selected norm.
    function automatic t_unit_quat normalize_quat(input logic [127:0] comps,
                                                  input logic [1:0] order);
        t_unit_quat  r;
        logic [31:0] comp;
        logic [63:0] mag [4];
        logic        neg [4];
        logic [64:0] sum;
        logic [63:0] l1;
        logic [63:0] root;
        logic [63:0] quo;
        logic [31:0] lane [4];
        sum = 0;
        l1 = 0;
        for (int i = 0; i < 4; i++) begin
            comp = comps[32*i +: 32];
            neg[i] = comp[31];
            mag[i] = {32'd0, neg[i] ? -comp : comp};
            sum = sum + mag[i] * mag[i];
            l1 = l1 + mag[i];
        end
        // A sum that overflows 64 bits only comes from four components of -2^31.
        root = sum[64] ? 64'h1_0000_0000 : floor_root(sum[63:0]);
        for (int i = 0; i < 4; i++) begin
            if (root == 0) begin
                lane[i] = 0;
            end else begin
                quo = (mag[i] << 30) / root;
                lane[i] = neg[i] ? -quo[31:0] : quo[31:0];
            end
        end
        r.unit_w = lane[0];
        r.unit_x = lane[1];
        r.unit_y = lane[2];
        r.unit_z = lane[3];
        r.zero_norm = (root == 0);
        if (order == qn_pkg::ORDER_L1) r.norm_value = l1[33:0];
        else if (order == qn_pkg::ORDER_L2) r.norm_value = root[33:0];
        else r.norm_value = 0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        o_pending = 0;
    end

    // Watch both channels at every rising edge.
    always @(posedge i_clk) begin
        t_unit_quat want;
        if (i_rst_n && i_in_valid && i_in_ready)
            unit_queue.push_back(normalize_quat(i_in_data, i_in_user));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            o_results_seen++;
            if (unit_queue.size() == 0) begin
                report_mismatch("unexpected word", i_out_data[63:0], 0);
            end else begin
                want = unit_queue.pop_front();
                if (i_out_data[31:0] !== want.unit_w)
                    report_mismatch("unit_w", i_out_data[31:0], want.unit_w);
                if (i_out_data[63:32] !== want.unit_x)
                    report_mismatch("unit_x", i_out_data[63:32], want.unit_x);
                if (i_out_data[95:64] !== want.unit_y)
                    report_mismatch("unit_y", i_out_data[95:64], want.unit_y);
                if (i_out_data[127:96] !== want.unit_z)
                    report_mismatch("unit_z", i_out_data[127:96], want.unit_z);
                if (i_out_data[161:128] !== want.norm_value)
                    report_mismatch("norm_value", i_out_data[161:128], want.norm_value);
                if (i_out_user !== want.zero_norm)
                    report_mismatch("zero_norm", i_out_user, want.zero_norm);
            end
        end
        o_pending = unit_queue.size();
    end
endmodule

// ===== tb/quaternion_normalize_tb.sv =====
// Top-level testbench for the quaternion normalizer: stimulus, stalls and verdict.
module quaternion_normalize_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1330;
    localparam int DRAIN_CYCLES = 150;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // comp_w, comp_x, comp_y, comp_z
    logic [1:0]   s_axis_tuser;   // norm_order
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;   // unit_w, unit_x, unit_y, unit_z, norm_value, pad
    logic         m_axis_tuser;   // zero_norm
    int           fail_count;
    int           pending;
    int           results_seen;
    int           words_sent;
    bit           hold_off_done;

    quaternion_normalize dut (.*);

    quaternion_normalize_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #3ms;
        $display("[quaternion_normalize] ERROR");
        $finish;
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_quat(input logic [31:0] w, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input logic [1:0] order);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x, w};
        s_axis_tuser <= order;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Component with a random magnitude class, from tiny to full scale.
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15) - 8;
            1: return $urandom() >> $urandom_range(4, 28);
            2: return -($urandom() >> $urandom_range(4, 28));
            3: return 32'h8000_0000 + $urandom_range(0, 3);
            4: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // Receiver stall pattern, plus one long hold-off while the sender runs on.
    initial begin
        int stall_mode;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_off_done && words_sent > 300) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(negedge i_clk);
                hold_off_done = 1'b1;
            end
            stall_mode = (words_sent / 200) % 3;
            if (stall_mode == 0) m_axis_tready <= 1'b1;
            else if (stall_mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
            else m_axis_tready <= ($urandom_range(0, 1) != 0);
        end
    end

    initial begin
        int burst;
        int wait_count;
        logic [1:0] order;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        words_sent = 0;
        hold_off_done = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed cases: zero norm, full-scale extremes, single axes, bad orders.
        send_quat(0, 0, 0, 0, qn_pkg::ORDER_L1);
        send_quat(0, 0, 0, 0, qn_pkg::ORDER_L2);
        send_quat(0, 0, 0, 0, 2'd0);
        send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  qn_pkg::ORDER_L2);
        send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  qn_pkg::ORDER_L1);
        send_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  qn_pkg::ORDER_L1);
        send_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  qn_pkg::ORDER_L2);
        send_quat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 2'd3);
        send_quat(32'h1000_0000, 0, 0, 0, qn_pkg::ORDER_L2);
        send_quat(0, 32'hF000_0000, 0, 0, qn_pkg::ORDER_L1);
        send_quat(0, 0, 32'h8000_0000, 0, qn_pkg::ORDER_L2);
        send_quat(0, 0, 0, 32'h7FFF_FFFF, qn_pkg::ORDER_L1);
        send_quat(1, 0, 0, 0, qn_pkg::ORDER_L2);
        send_quat(0, 0, 0, 32'hFFFF_FFFF, qn_pkg::ORDER_L2);
        send_quat(1, 1, 1, 1, qn_pkg::ORDER_L2);
        send_quat(32'h1000_0000, 32'hF000_0000, 32'h1000_0000, 32'hF000_0000, 2'd0);
        send_quat(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 2'd3);

        // Random bursts with random gaps.
        while (words_sent < 17 + RANDOM_WORDS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                order = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                    : 2'($urandom_range(1, 2));
                if ($urandom_range(0, 19) == 0)
                    send_quat(0, 0, 0, 0, order);
                else
                    send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), order);
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow the pipeline latency to expose stray words.
        while (pending != 0) @(negedge i_clk);
        wait_count = 0;
        while (wait_count < DRAIN_CYCLES) begin
            @(negedge i_clk);
            wait_count++;
        end

        $display("Sent %0d quaternions, including zero, full-scale and unsupported-order cases;",
                 words_sent);
        $display("checked %0d normalized words under output stalls and a long hold-off.",
                 results_seen);
        if (fail_count == 0) begin
            $display("[quaternion_normalize] OK");
        end else begin
            $display("[quaternion_normalize] ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/qn_pkg.sv
rtl/qn_sqrt.sv
rtl/qn_div_lane.sv
rtl/quaternion_normalize.sv
tb/quaternion_normalize_checker.sv
tb/quaternion_normalize_tb.sv
